// ===== sv/chacha20_keystream_xor_macros.svh =====
// Assertion macros used by the ChaCha20 keystream XOR port checks
`ifndef CHACHA20_KEYSTREAM_XOR_MACROS_SVH
`define CHACHA20_KEYSTREAM_XOR_MACROS_SVH

// Property checked while out of reset
`define CCKS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included
`define CCKS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/ccks_pkg.sv =====
// Shared types and constants for the ChaCha20 keystream XOR block
package ccks_pkg;

    localparam int BLOCK_BYTES = 64;
    localparam int POS_W       = 7;    // holds 0..64
    localparam int ROUND_STEPS = 80;   // 20 rounds, four add/xor/rotate steps each
    localparam int STEP_W      = $clog2(ROUND_STEPS);
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_PART_0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_PART_1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_PART_2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_PART_3   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE_LOWER  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE_UPPER  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_START_COUNTER = 3'd6;

    // "expand 32-byte k", little-endian words
    localparam logic [31:0] SIGMA [4] = '{
        32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic       load;       // capture byte, load block input state
        logic       step;       // one round step
        logic       diag;       // diagonal round when set
        logic [1:0] sub;        // step within the quarter round
        logic       add;        // add input state back, bump counter
        logic       emit_in;    // result from the incoming byte
        logic       emit_held;  // result from the captured byte
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic pos_full;         // block used up
    } t_status;

endpackage

// ===== sv/chacha20_keystream_xor.sv =====
// ChaCha20 keystream XOR, one data byte per word, top level
// A byte within a block gives its result from the output register in the next cycle; one that
// starts a block waits for 80 round steps on four shared quarter-round units, add and output.
// Throughput: one byte per cycle for 63 of every 64 bytes unless the output stalls.
// Reset: synchronous, active low; config, counter and state clear, first byte builds a block.
module chacha20_keystream_xor (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ccks_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ccks_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [7:0]                       i_data_byte,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [7:0]                       o_out_byte
);

    ccks_pkg::t_cmd    cmd;
    ccks_pkg::t_status status;

    ccks_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    ccks_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_data_byte (i_data_byte),
        .i_cmd       (cmd),
        .o_out_byte  (o_out_byte),
        .o_status    (status)
    );

endmodule

// ===== sv/ccks_datapath.sv =====
// ChaCha20 datapath: config registers, working state, round logic and output byte
module ccks_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ccks_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ccks_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic [7:0]                       i_data_byte,
    input  ccks_pkg::t_cmd                   i_cmd,
    output logic [7:0]                       o_out_byte,
    output ccks_pkg::t_status                o_status
);

    logic [63:0]              r_key [4];
    logic [63:0]              r_nonce_lower;
    logic [31:0]              r_nonce_upper;
    logic [63:0]              r_start;
    logic [63:0]              r_ctr;
    logic [ccks_pkg::POS_W-1:0] r_pos;
    logic [31:0]              r_w [16];
    logic [31:0]              n_w [16];
    logic [31:0]              init [16];
    logic [7:0]               r_held;
    logic [7:0]               r_out_byte;
    logic [31:0]              ks_word;
    logic [7:0]               ks_byte;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
        rotl = (v << s) | (v >> (32 - s));
    endfunction

    // block input state
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            init[i]         = ccks_pkg::SIGMA[i];
            init[4 + 2 * i] = r_key[i][31:0];
            init[5 + 2 * i] = r_key[i][63:32];
        end
        init[12] = r_ctr[31:0];
        init[13] = r_nonce_lower[31:0] + r_ctr[63:32];
        init[14] = r_nonce_lower[63:32];
        init[15] = r_nonce_upper;
    end

    // one step of four quarter rounds in parallel, or load, or final add
    always_comb begin
        logic [3:0]  ia, ib, ic, id;
        logic [1:0]  q2;
        logic [31:0] sum_ab, sum_cd;
        ia = '0; ib = '0; ic = '0; id = '0;
        q2 = '0;
        sum_ab = '0; sum_cd = '0;
        n_w = r_w;
        if (i_cmd.load) begin
            n_w = init;
        end else if (i_cmd.add) begin
            for (int i = 0; i < 16; i++) n_w[i] = r_w[i] + init[i];
        end else if (i_cmd.step) begin
            for (int q = 0; q < 4; q++) begin
                q2 = 2'(q);
                ia = {2'b00, q2};
                ib = {2'b01, q2 + (i_cmd.diag ? 2'd1 : 2'd0)};
                ic = {2'b10, q2 + (i_cmd.diag ? 2'd2 : 2'd0)};
                id = {2'b11, q2 + (i_cmd.diag ? 2'd3 : 2'd0)};
                sum_ab = r_w[ia] + r_w[ib];
                sum_cd = r_w[ic] + r_w[id];
                case (i_cmd.sub)
                    2'd0: begin
                        n_w[ia] = sum_ab;
                        n_w[id] = rotl(r_w[id] ^ sum_ab, 16);
                    end
                    2'd1: begin
                        n_w[ic] = sum_cd;
                        n_w[ib] = rotl(r_w[ib] ^ sum_cd, 12);
                    end
                    2'd2: begin
                        n_w[ia] = sum_ab;
                        n_w[id] = rotl(r_w[id] ^ sum_ab, 8);
                    end
                    default: begin
                        n_w[ic] = sum_cd;
                        n_w[ib] = rotl(r_w[ib] ^ sum_cd, 7);
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_w <= n_w;
    end

    // keystream byte at the current position, little-endian within the word
    assign ks_word = r_w[r_pos[5:2]];
    assign ks_byte = ks_word[{r_pos[1:0], 3'b000} +: 8];

    // held byte and result byte
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_held <= i_data_byte;
        if (i_cmd.emit_in) begin
            r_out_byte <= i_data_byte ^ ks_byte;
        end else if (i_cmd.emit_held) begin
            r_out_byte <= r_held ^ ks_byte;
        end
    end

    // configuration, block counter and byte position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) r_key[i] <= '0;
            r_nonce_lower <= '0;
            r_nonce_upper <= '0;
            r_start       <= '0;
            r_ctr         <= '0;
            r_pos         <= ccks_pkg::POS_W'(ccks_pkg::BLOCK_BYTES);
        end else if (i_cfg_we) begin
            // any listed register restarts the stream
            case (i_cfg_index)
                ccks_pkg::CFG_KEY_PART_0: begin
                    r_key[0] <= i_cfg_data;
                    r_ctr    <= r_start;
                    r_pos    <= ccks_pkg::POS_W'(ccks_pkg::BLOCK_BYTES);
                end
                ccks_pkg::CFG_KEY_PART_1: begin
                    r_key[1] <= i_cfg_data;
                    r_ctr    <= r_start;
                    r_pos    <= ccks_pkg::POS_W'(ccks_pkg::BLOCK_BYTES);
                end
                ccks_pkg::CFG_KEY_PART_2: begin
                    r_key[2] <= i_cfg_data;
                    r_ctr    <= r_start;
                    r_pos    <= ccks_pkg::POS_W'(ccks_pkg::BLOCK_BYTES);
                end
                ccks_pkg::CFG_KEY_PART_3: begin
                    r_key[3] <= i_cfg_data;
                    r_ctr    <= r_start;
                    r_pos    <= ccks_pkg::POS_W'(ccks_pkg::BLOCK_BYTES);
                end
                ccks_pkg::CFG_NONCE_LOWER: begin
                    r_nonce_lower <= i_cfg_data;
                    r_ctr         <= r_start;
                    r_pos         <= ccks_pkg::POS_W'(ccks_pkg::BLOCK_BYTES);
                end
                ccks_pkg::CFG_NONCE_UPPER: begin
                    r_nonce_upper <= i_cfg_data[31:0];
                    r_ctr         <= r_start;
                    r_pos         <= ccks_pkg::POS_W'(ccks_pkg::BLOCK_BYTES);
                end
                ccks_pkg::CFG_START_COUNTER: begin
                    r_start <= i_cfg_data;
                    r_ctr   <= i_cfg_data;
                    r_pos   <= ccks_pkg::POS_W'(ccks_pkg::BLOCK_BYTES);
                end
                default: ;  // unlisted index: ignored
            endcase
        end else begin
            if (i_cmd.add) begin
                r_ctr <= r_ctr + 64'd1;
                r_pos <= '0;
            end else if (i_cmd.emit_in || i_cmd.emit_held) begin
                r_pos <= r_pos + ccks_pkg::POS_W'(1);
            end
        end
    end

    assign o_status.pos_full = (r_pos == ccks_pkg::POS_W'(ccks_pkg::BLOCK_BYTES));
    assign o_out_byte        = r_out_byte;

endmodule

// ===== sv/ccks_ctrl.sv =====
// ChaCha20 controller: handshakes, round sequencing and output valid
module ccks_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  ccks_pkg::t_status i_status,
    output ccks_pkg::t_cmd    o_cmd
);

    ccks_pkg::t_state              r_state, n_state;
    logic [ccks_pkg::STEP_W-1:0]   r_step, n_step;
    logic                          r_out_valid, n_out_valid;
    logic                          out_free;
    logic                          accept;

    // output register can take a word this cycle
    assign out_free = !r_out_valid || !i_out_stall;
    assign accept   = (r_state == ccks_pkg::ST_IDLE) && i_in_valid && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ccks_pkg::ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        case (r_state)
            ccks_pkg::ST_IDLE: begin
                if (accept) begin
                    if (i_status.pos_full) begin
                        o_cmd.load = 1'b1;
                        n_step     = '0;
                        n_state    = ccks_pkg::ST_ROUND;
                    end else begin
                        o_cmd.emit_in = 1'b1;
                    end
                end
            end
            ccks_pkg::ST_ROUND: begin
                o_cmd.step = 1'b1;
                o_cmd.sub  = r_step[1:0];
                o_cmd.diag = r_step[2];
                n_step     = r_step + ccks_pkg::STEP_W'(1);
                if (r_step == ccks_pkg::STEP_W'(ccks_pkg::ROUND_STEPS - 1)) begin
                    n_state = ccks_pkg::ST_ADD;
                end
            end
            ccks_pkg::ST_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = ccks_pkg::ST_EMIT;
            end
            ccks_pkg::ST_EMIT: begin
                if (out_free) begin
                    o_cmd.emit_held = 1'b1;
                    n_state         = ccks_pkg::ST_IDLE;
                end
            end
            default: n_state = ccks_pkg::ST_IDLE;
        endcase

        // result word held until taken
        if (o_cmd.emit_in || o_cmd.emit_held) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_in_stall  = !((r_state == ccks_pkg::ST_IDLE) && out_free);
    assign o_out_valid = r_out_valid;

endmodule

// ===== sv/ccks_checker.sv =====
// Port-level checks for the ChaCha20 keystream XOR block, with bind
`include "chacha20_keystream_xor_macros.svh"

module ccks_port_checks (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_cfg_we,
    input logic [ccks_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input logic [ccks_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input logic                             i_in_valid,
    input logic                             o_in_stall,
    input logic [7:0]                       i_data_byte,
    input logic                             o_out_valid,
    input logic                             i_out_stall,
    input logic [7:0]                       o_out_byte
);

    // stalled result word holds
    `CCKS_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_byte), "result word changed under stall")
    // no result pending straight after reset
    `CCKS_ASSERT_ALWAYS(a_rst_clear, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")
    // input taken only when the output register has room
    `CCKS_ASSERT(a_room, i_clk, i_rst_n, !o_in_stall |-> !o_out_valid || !i_out_stall, "input open while output blocked")
    // an accepted byte either gives a result next cycle or keeps the input closed
    `CCKS_ASSERT(a_progress, i_clk, i_rst_n, i_in_valid && !o_in_stall |=> o_out_valid || o_in_stall, "accepted byte lost")

endmodule

bind chacha20_keystream_xor ccks_port_checks u_ccks_port_checks (.*);

// ===== bench/ccks_checker.sv =====
// Checker for the ChaCha20 keystream XOR block: watches both channels, predicts and compares
`timescale 1ns / 1ps

module ccks_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ccks_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ccks_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_in_valid,
    input  logic                             i_in_stall,
    input  logic [7:0]                       i_data_byte,
    input  logic                             i_out_valid,
    input  logic                             i_out_stall,
    input  logic [7:0]                       i_out_byte,
    output int                               o_fail_count,
    output int                               o_pending
);

    // shadow of the configuration registers
    logic [63:0] key_part [4];
    logic [63:0] nonce_lo;
    logic [31:0] nonce_hi;
    logic [63:0] start_ctr;

    // keystream state
    logic [63:0] blk_ctr;
    logic [31:0] ks_words [16];
    logic [31:0] mix [16];
    int unsigned ks_pos;

    logic [7:0] expected_bytes [$];
    logic [7:0] want;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // one line per mismatch, and count it
    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] exp_val);
        $display("[%0t] %s: got %02h, expected %02h", $time, what, got, exp_val);
        o_fail_count++;
    endtask

    function automatic logic [31:0] rotl32(input logic [31:0] v, input int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    function automatic void quarter_round(input int a, input int b, input int c, input int d);
        mix[a] = mix[a] + mix[b]; mix[d] = rotl32(mix[d] ^ mix[a], 16);
        mix[c] = mix[c] + mix[d]; mix[b] = rotl32(mix[b] ^ mix[c], 12);
        mix[a] = mix[a] + mix[b]; mix[d] = rotl32(mix[d] ^ mix[a], 8);
        mix[c] = mix[c] + mix[d]; mix[b] = rotl32(mix[b] ^ mix[c], 7);
    endfunction

    // build the next 64-byte block and bump the counter
    function automatic void next_block();
        logic [31:0] init [16];
        int i;
        int r;
        for (i = 0; i < 4; i++) begin
            init[i]         = ccks_pkg::SIGMA[i];
            init[4 + 2 * i] = key_part[i][31:0];
            init[5 + 2 * i] = key_part[i][63:32];
        end
        init[12] = blk_ctr[31:0];
        init[13] = nonce_lo[31:0] + blk_ctr[63:32];   // high counter half rides on nonce word 0
        init[14] = nonce_lo[63:32];
        init[15] = nonce_hi;
        for (i = 0; i < 16; i++)
            mix[i] = init[i];
        for (r = 0; r < 10; r++) begin
            for (i = 0; i < 4; i++)
                quarter_round(i, 4 + i, 8 + i, 12 + i);
            for (i = 0; i < 4; i++)
                quarter_round(i, 4 + ((i + 1) % 4), 8 + ((i + 2) % 4), 12 + ((i + 3) % 4));
        end
        for (i = 0; i < 16; i++)
            ks_words[i] = mix[i] + init[i];
        blk_ctr = blk_ctr + 64'd1;   // wraps at 2^64
    endfunction

    // expected output for one accepted data byte
    function automatic logic [7:0] cipher_byte(input logic [7:0] b);
        logic [31:0] w;
        if (ks_pos >= ccks_pkg::BLOCK_BYTES) begin
            next_block();
            ks_pos = 0;
        end
        w = ks_words[ks_pos >> 2];
        cipher_byte = b ^ w[8 * (ks_pos % 4) +: 8];
        ks_pos++;
    endfunction

    function automatic void restart_stream();
        blk_ctr = start_ctr;
        ks_pos  = ccks_pkg::BLOCK_BYTES;
    endfunction

    // register write; an unlisted index changes nothing
    function automatic void apply_cfg(input logic [ccks_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [63:0] val);
        case (idx)
            ccks_pkg::CFG_KEY_PART_0, ccks_pkg::CFG_KEY_PART_1,
            ccks_pkg::CFG_KEY_PART_2, ccks_pkg::CFG_KEY_PART_3: begin
                key_part[idx[1:0]] = val;
                restart_stream();
            end
            ccks_pkg::CFG_NONCE_LOWER: begin
                nonce_lo = val;
                restart_stream();
            end
            ccks_pkg::CFG_NONCE_UPPER: begin
                nonce_hi = val[31:0];
                restart_stream();
            end
            ccks_pkg::CFG_START_COUNTER: begin
                start_ctr = val;
                restart_stream();
            end
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++)
                key_part[i] = '0;
            nonce_lo  = '0;
            nonce_hi  = '0;
            start_ctr = '0;
            for (int i = 0; i < 16; i++)
                ks_words[i] = '0;
            restart_stream();
            expected_bytes.delete();
        end else begin
            if (i_cfg_we)
                apply_cfg(i_cfg_index, i_cfg_data);
            // result side
            if (i_out_valid && !i_out_stall) begin
                if (expected_bytes.size() == 0) begin
                    report_mismatch("out_byte with nothing pending", i_out_byte, 8'h00);
                end else begin
                    want = expected_bytes.pop_front();
                    if (i_out_byte !== want)
                        report_mismatch("out_byte", i_out_byte, want);
                end
            end
            // input side
            if (i_in_valid && !i_in_stall)
                expected_bytes.push_back(cipher_byte(i_data_byte));
        end
        o_pending = expected_bytes.size();
    end

endmodule

// ===== bench/tb_top.sv =====
// Top of the ChaCha20 keystream XOR testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int RANDOM_BYTES   = 1800;
    localparam int DRAIN_CYCLES   = 200;
    localparam int NUM_IDX        = 1 << ccks_pkg::CFG_IDX_W;
    localparam logic [ccks_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            cfg_we    = 1'b0;
    logic [ccks_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [ccks_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    logic                            in_valid  = 1'b0;
    logic                            in_stall;
    logic [7:0]                      data_byte = 8'h00;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic [7:0]                      out_byte;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int bytes_sent  = 0;
    bit gapless     = 1'b0;

    logic [ccks_pkg::CFG_DATA_W-1:0] cfg_val [NUM_IDX];

    chacha20_keystream_xor dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_data_byte (data_byte),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_byte  (out_byte)
    );

    ccks_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_data_byte  (data_byte),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_byte   (out_byte),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver back-pressure: segments of random length, mostly short
    int stall_left = 0;
    bit stall_level = 1'b0;
    always @(negedge clk) begin
        int r;
        if (stall_left == 0) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                stall_level = 1'b0; stall_left = $urandom_range(1, 8);
            end else if (r < 85) begin
                stall_level = 1'b1; stall_left = $urandom_range(1, 3);
            end else if (r < 95) begin
                stall_level = 1'b0; stall_left = $urandom_range(20, 80);
            end else begin
                stall_level = 1'b1; stall_left = $urandom_range(10, 30);
            end
        end
        stall_left--;
        out_stall <= stall_level;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (gapless || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(15, 30);
    endfunction

    function automatic logic [63:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2)
            return '0;
        else if (r < 4)
            return '1;
        else
            return {$urandom, $urandom};
    endfunction

    // counter starts near the 32-bit carry and the 64-bit wrap are favoured
    function automatic logic [63:0] pick_counter();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 3);
        else if (r < 6)
            return 64'h0000_0000_FFFF_FFFF - $urandom_range(0, 3);
        else
            return pick_value();
    endfunction

    // entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_burst(input int n);
        repeat (n)
            send_byte(8'($urandom));
        in_valid <= 1'b0;
    endtask

    // wait until every result is back, then a few quiet cycles
    task automatic wait_idle();
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // write every register flagged in the mask, one per cycle
    task automatic write_cfg(input logic [NUM_IDX-1:0] mask);
        for (int idx = 0; idx < NUM_IDX; idx++) begin
            if (mask[idx]) begin
                cfg_we    <= 1'b1;
                cfg_index <= idx[ccks_pkg::CFG_IDX_W-1:0];
                cfg_data  <= cfg_val[idx];
                @(negedge clk);
            end
        end
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    initial begin
        logic [NUM_IDX-1:0] mask;
        logic [7:0]         corner [8];
        int                 r;

        corner = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h55, 8'hAA};

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: first bytes after reset build a block from the all-zero setup
        gapless = 1'b1;
        foreach (corner[i])
            send_byte(corner[i]);
        send_byte(8'($urandom));
        send_byte(8'($urandom));
        in_valid <= 1'b0;
        wait_idle();

        // unlisted index must not restart the stream
        mask = '0;
        mask[CFG_UNUSED_IDX] = 1'b1;
        cfg_val[CFG_UNUSED_IDX] = '1;
        write_cfg(mask);
        gapless = 1'b0;
        send_burst(6);
        wait_idle();

        // all registers at all ones; counter at the top so the next block wraps
        mask = '0;
        for (int idx = ccks_pkg::CFG_KEY_PART_0; idx <= ccks_pkg::CFG_START_COUNTER; idx++) begin
            mask[idx]    = 1'b1;
            cfg_val[idx] = '1;
        end
        write_cfg(mask);
        send_burst(8);
        wait_idle();

        // random phases
        while (bytes_sent < RANDOM_BYTES) begin
            r = $urandom_range(0, 9);
            mask = '0;
            if (r == 0) begin
                mask[CFG_UNUSED_IDX] = 1'b1;
                cfg_val[CFG_UNUSED_IDX] = {$urandom, $urandom};
            end else if (r < 9) begin
                for (int idx = ccks_pkg::CFG_KEY_PART_0;
                     idx <= ccks_pkg::CFG_START_COUNTER; idx++) begin
                    mask[idx]    = 1'($urandom_range(0, 1));
                    cfg_val[idx] = pick_value();
                end
                cfg_val[ccks_pkg::CFG_START_COUNTER] = pick_counter();
                if (mask == '0)
                    mask[ccks_pkg::CFG_START_COUNTER] = 1'b1;
            end
            if (mask != '0)
                write_cfg(mask);

            gapless = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 80)
                send_burst($urandom_range(1, 100));
            else if (r < 95)
                send_burst($urandom_range(100, 200));
            else
                send_burst($urandom_range(200, 400));
            wait_idle();
        end

        // drain
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/ccks_pkg.sv
sv/ccks_datapath.sv
sv/ccks_ctrl.sv
sv/chacha20_keystream_xor.sv
sv/ccks_checker.sv
bench/ccks_checker.sv
bench/tb_top.sv
